FILE: src/mlpfp_pkg.sv
// Shared constants, widths and the sigmoid table for the perceptron block.
package mlpfp_pkg;

    localparam int INPUT_COUNT  = 8;
    localparam int HIDDEN_COUNT = 8;
    localparam int OUTPUT_COUNT = 4;
    localparam int WEIGHT_DEPTH = 128;

    localparam int RESULT_LIMIT = 4;
    localparam int RESULT_COUNT = (OUTPUT_COUNT < RESULT_LIMIT) ? OUTPUT_COUNT : RESULT_LIMIT;

    localparam int OUT_BASE    = HIDDEN_COUNT * (INPUT_COUNT + 1);
    localparam int WEIGHT_SPAN = OUT_BASE + OUTPUT_COUNT * (HIDDEN_COUNT + 1);
    localparam int ADDR_MAX    = (WEIGHT_SPAN > WEIGHT_DEPTH) ? WEIGHT_SPAN : WEIGHT_DEPTH;

    localparam int WD_W = $clog2(WEIGHT_DEPTH);
    localparam int WA_W = $clog2(ADDR_MAX + 1);

    localparam int IN_IW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int HID_IW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;

    localparam int TERM_MAX = ((INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT) + 1;
    localparam int TW       = $clog2(TERM_MAX + 1);

    localparam int NEURON_MAX = (HIDDEN_COUNT > RESULT_COUNT) ? HIDDEN_COUNT : RESULT_COUNT;
    localparam int NW         = (NEURON_MAX > 1) ? $clog2(NEURON_MAX) : 1;

    // Bias multipliers: hidden sums take w*2048, output sums take (w*4096)/2
    localparam logic signed [16:0] BIAS_X_HID = 17'sd2048;
    localparam logic signed [16:0] BIAS_X_OUT = 17'sd4096;
    localparam logic [12:0]        ACT_ONE    = 13'd4096;
    localparam logic [11:0]        SIG_TOP    = 12'd4095;

    // round(4096*sigmoid(k/2)) for k = 0..16
    function automatic logic [11:0] sig_table(input logic [4:0] k);
        logic [11:0] v;
        case (k)
            5'd0:    v = 12'd2048;
            5'd1:    v = 12'd2550;
            5'd2:    v = 12'd2994;
            5'd3:    v = 12'd3349;
            5'd4:    v = 12'd3608;
            5'd5:    v = 12'd3785;
            5'd6:    v = 12'd3902;
            5'd7:    v = 12'd3976;
            5'd8:    v = 12'd4022;
            5'd9:    v = 12'd4051;
            5'd10:   v = 12'd4069;
            5'd11:   v = 12'd4079;
            5'd12:   v = 12'd4086;
            5'd13:   v = 12'd4090;
            5'd14:   v = 12'd4092;
            5'd15:   v = 12'd4094;
            default: v = 12'd4095;
        endcase
        return v;
    endfunction

endpackage

FILE: src/mlp_forward_pass.sv
// Two-layer perceptron inference on one shared multiply-accumulate unit.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  mode, slot, item_value, end_of_vector
//   out      source     out_valid/out_ready  neuron, activation, final_result
//
// A weight write or a feature load without end mark leaves the block idle.
// A pass runs neuron by neuron on the shared MAC: terms issue one a cycle, the
// read/multiply/add pipe drains, then the sigmoid runs its magnitude, table and
// output states; each output neuron then holds its result word until taken.
// in_ready stays low for the whole pass; each result word waits in the output
// register until taken, and the next output neuron starts only after that.
// Reset clears the feature buffer, accumulator and control; weights need writing.
module mlp_forward_pass (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [6:0]  slot,
    input  logic [15:0] item_value,
    input  logic        end_of_vector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  neuron,
    output logic [12:0] activation,
    output logic        final_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_SIG_ABS,
        ST_SIG_MUL,
        ST_SIG_OUT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // control
    logic                              out_layer_reg;
    logic [mlpfp_pkg::NW-1:0]          n_reg;
    logic [mlpfp_pkg::TW-1:0]          t_reg;
    logic [mlpfp_pkg::WA_W-1:0]        base_reg;
    logic                              v1_reg;
    logic                              v2_reg;
    logic                              first1_reg;
    logic                              first2_reg;
    logic signed [31:0]                acc_reg;
    logic signed [15:0]                feat_reg [mlpfp_pkg::INPUT_COUNT];
    logic                              out_valid_reg;
    logic [1:0]                        neuron_reg;
    logic [12:0]                       act_reg;
    logic                              final_reg;

    // datapath payload
    logic signed [16:0]                x_reg;
    logic                              sh_reg;
    logic signed [32:0]                prod_reg;
    logic [12:0]                       hid_reg [mlpfp_pkg::HIDDEN_COUNT];
    logic [31:0]                       mag_reg;
    logic                              neg_reg;
    logic [11:0]                       sig_base_reg;
    logic [8:0]                        sig_frac_reg;

    // weight memory
    logic [15:0]                       wmem [mlpfp_pkg::WEIGHT_DEPTH];
    logic [15:0]                       rd_data_reg;
    logic                              rd_zero_reg;

    logic                              in_fire;
    logic                              wr_en;
    logic [mlpfp_pkg::WA_W-1:0]        raddr;
    logic [mlpfp_pkg::TW-1:0]          terms;
    logic                              last_term;
    logic [mlpfp_pkg::IN_IW-1:0]       feat_idx;
    logic [mlpfp_pkg::HID_IW-1:0]      hid_idx;
    logic signed [16:0]                x_next;
    logic signed [15:0]                w_op;
    logic signed [32:0]                mult_full;
    logic signed [32:0]                prod_next;
    logic signed [33:0]                sum_full;
    logic signed [31:0]                acc_next;
    logic [31:0]                       mag_next;
    logic [3:0]                        sig_idx;
    logic                              sig_big;
    logic [11:0]                       sig_lo;
    logic [11:0]                       sig_hi;
    logic [8:0]                        sig_d;
    logic [29:0]                       sig_prod;
    logic [12:0]                       sig_y;
    logic [12:0]                       sig_result;
    logic                              last_hidden;
    logic                              last_output;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign wr_en        = in_fire && !mode && (32'(slot) < mlpfp_pkg::WEIGHT_DEPTH);
    assign out_valid    = out_valid_reg;
    assign neuron       = neuron_reg;
    assign activation   = act_reg;
    assign final_result = final_reg;

    assign raddr     = mlpfp_pkg::WA_W'(base_reg + mlpfp_pkg::WA_W'(t_reg));
    assign terms     = out_layer_reg ? mlpfp_pkg::TW'(mlpfp_pkg::HIDDEN_COUNT + 1)
                                     : mlpfp_pkg::TW'(mlpfp_pkg::INPUT_COUNT + 1);
    assign last_term = (t_reg == terms - 1'b1);
    assign feat_idx  = mlpfp_pkg::IN_IW'(t_reg - 1'b1);
    assign hid_idx   = mlpfp_pkg::HID_IW'(t_reg - 1'b1);

    assign last_hidden = (n_reg == mlpfp_pkg::NW'(mlpfp_pkg::HIDDEN_COUNT - 1));
    assign last_output = (n_reg == mlpfp_pkg::NW'(mlpfp_pkg::RESULT_COUNT - 1));

    // operand for the term being issued: bias scale or feature / hidden activation
    always_comb
    begin
        if (t_reg == '0)
        begin
            x_next = out_layer_reg ? mlpfp_pkg::BIAS_X_OUT : mlpfp_pkg::BIAS_X_HID;
        end
        else if (out_layer_reg)
        begin
            x_next = signed'({4'd0, hid_reg[hid_idx]});
        end
        else
        begin
            x_next = 17'(feat_reg[feat_idx]);
        end
    end

    // shared MAC: multiply, halve for the output layer, then saturating add
    assign w_op      = rd_zero_reg ? 16'sd0 : signed'(rd_data_reg);
    assign mult_full = x_reg * w_op;
    assign prod_next = sh_reg ? (mult_full >>> 1) : mult_full;
    assign sum_full  = (first2_reg ? 34'sd0 : 34'(acc_reg)) + 34'(prod_reg);

    always_comb
    begin
        if (sum_full[33:31] == 3'b000 || sum_full[33:31] == 3'b111)
        begin
            acc_next = sum_full[31:0];
        end
        else if (sum_full[33])
        begin
            acc_next = 32'sh8000_0000;
        end
        else
        begin
            acc_next = 32'sh7FFF_FFFF;
        end
    end

    // sigmoid: magnitude, table interpolation, mirror for negative sums
    assign mag_next   = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
    assign sig_idx    = mag_reg[24:21];
    assign sig_big    = |mag_reg[31:25];
    assign sig_lo     = mlpfp_pkg::sig_table({1'b0, sig_idx});
    assign sig_hi     = mlpfp_pkg::sig_table(5'({1'b0, sig_idx}) + 5'd1);
    assign sig_d      = 9'(sig_hi - sig_lo);
    assign sig_prod   = 30'(sig_d) * 30'(mag_reg[20:0]);
    assign sig_y      = 13'(sig_base_reg) + 13'(sig_frac_reg);
    assign sig_result = neg_reg ? (mlpfp_pkg::ACT_ONE - sig_y) : sig_y;

    // weight store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wmem[mlpfp_pkg::WD_W'(slot)] <= item_value;
        end
        rd_data_reg <= wmem[raddr[mlpfp_pkg::WD_W-1:0]];
        rd_zero_reg <= (raddr >= mlpfp_pkg::WA_W'(mlpfp_pkg::WEIGHT_DEPTH));
    end

    // datapath payload, no reset
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        sh_reg   <= out_layer_reg;
        prod_reg <= prod_next;
        if (state_reg == ST_SIG_ABS)
        begin
            mag_reg <= mag_next;
            neg_reg <= acc_reg[31];
        end
        if (state_reg == ST_SIG_MUL)
        begin
            sig_base_reg <= sig_big ? mlpfp_pkg::SIG_TOP : sig_lo;
            sig_frac_reg <= sig_big ? 9'd0 : sig_prod[29:21];
        end
        if (state_reg == ST_SIG_OUT && !out_layer_reg)
        begin
            hid_reg[mlpfp_pkg::HID_IW'(n_reg)] <= sig_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_layer_reg <= 1'b0;
            n_reg         <= '0;
            t_reg         <= '0;
            base_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            first2_reg    <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < mlpfp_pkg::INPUT_COUNT; i++)
            begin
                feat_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            neuron_reg    <= '0;
            act_reg       <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            // MAC pipeline: read -> multiply -> accumulate
            v1_reg     <= (state_reg == ST_ISSUE);
            first1_reg <= (t_reg == '0);
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            if (v2_reg)
            begin
                acc_reg <= acc_next;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && mode)
                    begin
                        if (32'(slot) < mlpfp_pkg::INPUT_COUNT)
                        begin
                            feat_reg[mlpfp_pkg::IN_IW'(slot)] <= signed'(item_value);
                        end
                        if (end_of_vector)
                        begin
                            state_reg     <= ST_ISSUE;
                            out_layer_reg <= 1'b0;
                            n_reg         <= '0;
                            t_reg         <= '0;
                            base_reg      <= '0;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    if (last_term)
                    begin
                        t_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    // wait until the last product has been added
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_SIG_ABS;
                    end
                end
                ST_SIG_ABS:
                begin
                    state_reg <= ST_SIG_MUL;
                end
                ST_SIG_MUL:
                begin
                    state_reg <= ST_SIG_OUT;
                end
                ST_SIG_OUT:
                begin
                    if (!out_layer_reg)
                    begin
                        if (last_hidden)
                        begin
                            out_layer_reg <= 1'b1;
                            n_reg         <= '0;
                            base_reg      <= mlpfp_pkg::WA_W'(mlpfp_pkg::OUT_BASE);
                        end
                        else
                        begin
                            n_reg    <= n_reg + 1'b1;
                            base_reg <= base_reg +
                                        mlpfp_pkg::WA_W'(mlpfp_pkg::INPUT_COUNT + 1);
                        end
                        state_reg <= ST_ISSUE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        neuron_reg    <= 2'(n_reg);
                        act_reg       <= sig_result;
                        final_reg     <= last_output;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // hold the word until taken
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_output)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            n_reg     <= n_reg + 1'b1;
                            base_reg  <= base_reg +
                                         mlpfp_pkg::WA_W'(mlpfp_pkg::HIDDEN_COUNT + 1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_input_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result word is pending");

    a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_result) |=> in_ready)
        else $error("block not idle after the final result word");

    a_pass_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode && end_of_vector) |=> !in_ready)
        else $error("end mark did not start a pass");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("accumulate stage fired without a multiply");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (activation <= mlpfp_pkg::ACT_ONE))
        else $error("activation above 1.0");

    a_sigmoid_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIG_ABS) |-> (!v1_reg && !v2_reg))
        else $error("sigmoid started before the MAC pipe drained");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the two-layer perceptron inference block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_WEIGHT  = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 250;
    localparam int LONG_HOLD    = 1500;

    typedef struct packed {
        logic        mode;
        logic [6:0]  slot;
        logic [15:0] value;
        logic        eov;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  neuron;
        logic [12:0] act;
        logic        last;
    } out_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [6:0]  slot = '0;
    logic [15:0] item_value = '0;
    logic        end_of_vector = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  neuron;
    logic [12:0] activation;
    logic        final_result;

    in_word_t  words_to_send [$];
    out_word_t outputs_due [$];
    in_word_t  next_word;
    out_word_t want;

    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    int words_queued = 0;
    int mismatches = 0;
    int cycles = 0;

    // predictor copy of the block state
    logic [15:0] weight_mem [mlpfp_pkg::WEIGHT_DEPTH];
    logic [15:0] feature_mem [mlpfp_pkg::INPUT_COUNT];
    int          hidden_act [mlpfp_pkg::HIDDEN_COUNT];

    mlp_forward_pass u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .slot          (slot),
        .item_value    (item_value),
        .end_of_vector (end_of_vector),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .neuron        (neuron),
        .activation    (activation),
        .final_result  (final_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int sat_acc(int a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(s);
    endfunction

    // round(4096*sigmoid(k/2))
    function automatic int logistic_knot(int k);
        case (k)
            0:       return 2048;
            1:       return 2550;
            2:       return 2994;
            3:       return 3349;
            4:       return 3608;
            5:       return 3785;
            6:       return 3902;
            7:       return 3976;
            8:       return 4022;
            9:       return 4051;
            10:      return 4069;
            11:      return 4079;
            12:      return 4086;
            13:      return 4090;
            14:      return 4092;
            15:      return 4094;
            default: return 4095;
        endcase
    endfunction

    function automatic int logistic_q12(int acc);
        longint mag;
        longint frac;
        longint y;
        int     k;
        mag  = (acc < 0) ? -longint'(acc) : longint'(acc);
        frac = mag & 64'h1F_FFFF;
        if ((mag >>> 21) >= 16)
            y = 4095;
        else
        begin
            k = int'(mag >>> 21);
            y = logistic_knot(k) +
                ((longint'(logistic_knot(k + 1) - logistic_knot(k)) * frac) >>> 21);
        end
        return (acc < 0) ? 4096 - int'(y) : int'(y);
    endfunction

    function automatic int weight_at(int addr);
        if (addr < mlpfp_pkg::WEIGHT_DEPTH)
            return int'($signed(weight_mem[addr]));
        return 0;
    endfunction

    task automatic evaluate_network();
        int        acc;
        int        base;
        out_word_t res;
        for (int h = 0; h < mlpfp_pkg::HIDDEN_COUNT; h++)
        begin
            base = h * (mlpfp_pkg::INPUT_COUNT + 1);
            acc  = sat_acc(0, longint'(weight_at(base)) * 2048);
            for (int i = 0; i < mlpfp_pkg::INPUT_COUNT; i++)
                acc = sat_acc(acc, longint'($signed(feature_mem[i])) *
                                   weight_at(base + 1 + i));
            hidden_act[h] = logistic_q12(acc);
        end
        for (int o = 0; o < mlpfp_pkg::RESULT_COUNT; o++)
        begin
            base = mlpfp_pkg::OUT_BASE + o * (mlpfp_pkg::HIDDEN_COUNT + 1);
            acc  = sat_acc(0, longint'(weight_at(base)) * 2048);
            // Q.23 product, halved toward minus infinity
            for (int h = 0; h < mlpfp_pkg::HIDDEN_COUNT; h++)
                acc = sat_acc(acc, (longint'(hidden_act[h]) *
                                    weight_at(base + 1 + h)) >>> 1);
            res.neuron = 2'(o);
            res.act    = 13'(logistic_q12(acc));
            res.last   = (o == mlpfp_pkg::RESULT_COUNT - 1);
            outputs_due.insert(outputs_due.size(), res);
        end
    endtask

    task automatic absorb_word(in_word_t w);
        if (w.mode == MODE_WEIGHT)
        begin
            if (int'(w.slot) < mlpfp_pkg::WEIGHT_DEPTH)
                weight_mem[w.slot] = w.value;
        end
        else
        begin
            if (int'(w.slot) < mlpfp_pkg::INPUT_COUNT)
                feature_mem[w.slot] = w.value;
            if (w.eov)
                evaluate_network();
        end
    endtask

    task automatic compare_field(string tag, logic [12:0] exp_v, logic [12:0] got);
        if (got !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, exp_v, got);
            mismatches++;
        end
    endtask

    // driver: one word on the bus at a time, held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            mode          <= 1'b0;
            slot          <= '0;
            item_value    <= '0;
            end_of_vector <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_word({mode, slot, item_value, end_of_vector});
            if (!in_valid || in_ready)
            begin
                if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    next_word = words_to_send.pop_front();
                    in_valid      <= 1'b1;
                    mode          <= next_word.mode;
                    slot          <= next_word.slot;
                    item_value    <= next_word.value;
                    end_of_vector <= next_word.eov;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each taken result word, throttle ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, %s %0d %0d %0d",
                             $time, "got neuron/activation/final", neuron, activation,
                             final_result);
                    mismatches++;
                end
                else
                begin
                    want = outputs_due.pop_front();
                    compare_field("neuron", 13'(want.neuron), 13'(neuron));
                    compare_field("activation", want.act, activation);
                    compare_field("final_result", 13'(want.last), 13'(final_result));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic put_word(logic m, logic [6:0] s, logic [15:0] v, logic e);
        in_word_t w;
        w.mode  = m;
        w.slot  = s;
        w.value = v;
        w.eov   = e;
        words_to_send.insert(words_to_send.size(), w);
        words_queued++;
    endtask

    function automatic logic [15:0] rand_q411();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1, 2:    return 16'(int'($urandom_range(0, 4095)) - 2048);
            3:       return 16'(int'($urandom_range(0, 511)) - 256);
            default:
                case ($urandom_range(0, 3))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
        endcase
    endfunction

    function automatic logic [6:0] feature_slot();
        if ($urandom_range(0, 7) == 0)
            return 7'($urandom_range(mlpfp_pkg::INPUT_COUNT, 127));
        return 7'($urandom_range(0, mlpfp_pkg::INPUT_COUNT - 1));
    endfunction

    // weight tweaks, feature loads, then usually the end mark
    task automatic queue_random_vector();
        int n_w;
        int n_f;
        n_w = $urandom_range(0, 6);
        n_f = $urandom_range(0, mlpfp_pkg::INPUT_COUNT);
        repeat (n_w)
            put_word(MODE_WEIGHT, 7'($urandom_range(0, 127)), rand_q411(),
                     1'($urandom_range(0, 1)));
        repeat (n_f)
            put_word(MODE_FEATURE, feature_slot(), rand_q411(), 1'b0);
        if ($urandom_range(0, 9) != 0)
            put_word(MODE_FEATURE, feature_slot(), rand_q411(), 1'b1);
    endtask

    task automatic run_phase(int s_idle, int r_idle, int count);
        int target;
        target    = words_queued + count;
        send_idle = s_idle;
        recv_idle = r_idle;
        while (words_queued < target)
            queue_random_vector();
    endtask

    task automatic drain_outputs();
        while (words_to_send.size() != 0 || in_valid || outputs_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < mlpfp_pkg::WEIGHT_DEPTH; i++)
            weight_mem[i] = '0;
        for (int i = 0; i < mlpfp_pkg::INPUT_COUNT; i++)
            feature_mem[i] = '0;
        send_idle = 18;
        recv_idle = 51;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every weight gets written before the first pass reads it
        for (int a = 0; a < mlpfp_pkg::WEIGHT_DEPTH; a++)
            put_word(MODE_WEIGHT, 7'(a), 16'(int'($urandom_range(0, 2047)) - 1024), 1'b0);

        // slot past the buffer still starts a pass on reset features
        put_word(MODE_FEATURE, 7'd127, 16'h7FFF, 1'b1);
        // end mark on a weight write does nothing
        put_word(MODE_WEIGHT, 7'd0, 16'h7FFF, 1'b1);
        put_word(MODE_WEIGHT, 7'd1, 16'h7FFF, 1'b0);
        // drive hidden neuron 0 into positive saturation
        for (int i = 0; i < mlpfp_pkg::INPUT_COUNT - 1; i++)
            put_word(MODE_FEATURE, 7'(i), 16'h7FFF, 1'b0);
        put_word(MODE_FEATURE, 7'(mlpfp_pkg::INPUT_COUNT - 1), 16'h7FFF, 1'b1);
        // and then into negative saturation
        for (int i = 0; i < 4; i++)
            put_word(MODE_WEIGHT, 7'(i), 16'h8000, 1'b0);
        put_word(MODE_FEATURE, 7'd0, 16'h7FFF, 1'b1);
        put_word(MODE_WEIGHT, 7'(mlpfp_pkg::OUT_BASE), 16'h7FFF, 1'b0);
        put_word(MODE_WEIGHT, 7'(mlpfp_pkg::OUT_BASE + 1), 16'h8000, 1'b0);
        put_word(MODE_FEATURE, 7'(mlpfp_pkg::INPUT_COUNT), 16'h0000, 1'b1);
        put_word(MODE_FEATURE, 7'd5, 16'h8000, 1'b0);
        put_word(MODE_FEATURE, 7'd6, 16'hFFFF, 1'b1);
        drain_outputs();

        run_phase(18, 51, 100);
        drain_outputs();
        run_phase(51, 18, 100);
        drain_outputs();
        // starve the output long enough for the block to back up its input
        hold_left = LONG_HOLD;
        run_phase(0, 0, 110);
        drain_outputs();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
